/* rtl/llpm_pkg.sv */
// ----------------------------------------------------------------------------
// llpm_pkg
// Shared types and constants for the linked-list pool manager.
// ----------------------------------------------------------------------------
package llpm_pkg;

    localparam int NUM_NODES  = 256;
    localparam int NUM_LISTS  = 4;
    localparam int DATA_WIDTH = 32;
    localparam int NODE_W     = $clog2(NUM_NODES);
    localparam int LINK_W     = NODE_W + 1;
    localparam int LIST_W     = $clog2(NUM_LISTS);

    typedef logic [LINK_W-1:0] t_link;

    // link value that means "no node"
    localparam t_link LINK_NONE = LINK_W'(NUM_NODES);

    typedef enum logic [2:0] {
        CMD_APPEND   = 3'd0,
        CMD_PREPEND  = 3'd1,
        CMD_POP_HEAD = 3'd2,
        CMD_POP_TAIL = 3'd3,
        CMD_UNLINK   = 3'd4,
        CMD_CLEAR    = 3'd5,
        CMD_DROP     = 3'd6,
        CMD_READ     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHK,
        S_RD,
        S_X1,
        S_X2,
        S_X3,
        S_FP1,
        S_FP2,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_INC,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_cmd                    cmd;
        logic [LIST_W-1:0]       list_id;
        logic [NODE_W-1:0]       node_index;
        t_link                   count;
        logic [DATA_WIDTH-1:0]   data_in;
    } t_item;

    typedef struct packed {
        t_status                 status;
        t_link                   touched_index;
        t_link                   head_index;
        t_link                   tail_index;
        t_link                   list_length;
        t_link                   free_count;
        logic [DATA_WIDTH-1:0]   data_out;
        t_link                   next_link;
        t_link                   prev_link;
    } t_result;

    typedef struct packed {
        logic                    rd_en;
        logic [NODE_W-1:0]       rd_addr;
        logic                    nx_we;
        logic [NODE_W-1:0]       nx_addr;
        t_link                   nx_wdata;
        logic                    pv_we;
        logic [NODE_W-1:0]       pv_addr;
        t_link                   pv_wdata;
        logic                    dt_we;
        logic [NODE_W-1:0]       dt_addr;
        logic [DATA_WIDTH-1:0]   dt_wdata;
    } t_ram_req;

    typedef struct packed {
        t_link                   next;
        t_link                   prev;
        logic [DATA_WIDTH-1:0]   data;
    } t_ram_rsp;

endpackage

/* rtl/linked_list_pool_manager.sv */
// ----------------------------------------------------------------------------
// linked_list_pool_manager
// Node pool of doubly linked lists plus a free list, driven by one command
// beat per result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per beat: opcode in tuser, operands in
//   tdata. Master channel returns exactly one result beat per command, with
//   the status code in tuser and indices, counts and read data in tdata.
//   Commands are handled one at a time by a small sequencer that steps the
//   link updates through the next/prev/data memories (one shared registered
//   read port) and one shared saturating counter unit. From accept to the
//   result-register load it steps S_CHK, S_DONE for a command rejected at
//   the check (pool full, list empty); S_CHK, S_X1, S_DONE for clear;
//   S_CHK, S_RD, S_X1, S_DONE for read and for an ignored drop; S_CHK, S_RD,
//   S_X1, S_X2, S_DONE for append and drop; S_CHK, S_RD, S_X1, S_X2, S_X3,
//   S_DONE for prepend; S_CHK, S_RD, S_X1, S_FP1, S_FP2, S_DONE for pop and
//   unlink. The result beat shows on the cycle after the load, and the next
//   command is taken in that cycle too.
//   After reset the link memories are swept into an index-ordered free chain,
//   one node per cycle; tready stays low until the sweep ends.
//   A stalled master side holds the result in the output register; one more
//   command can be processed meanwhile, its result waiting in the sequencer.
// ----------------------------------------------------------------------------
module linked_list_pool_manager
    import llpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: command beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // list_id[1:0], node_index[9:2], count[18:10],
                                     // data_in[50:19], zero pad
    input  logic [2:0]  i_s_tuser,   // cmd
    // master side: result beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // touched_index[8:0], head_index[17:9],
                                     // tail_index[26:18], list_length[35:27],
                                     // free_count[44:36], data_out[76:45],
                                     // next_link[85:77], prev_link[94:86], zero pad
    output logic [1:0]  o_m_tuser    // status
);

    t_item    item;
    t_result  seq_res;
    logic     seq_res_valid;
    logic     seq_res_ready;
    t_ram_req ram_req;
    t_ram_rsp ram_rsp;

    logic    r_ovalid;
    t_result r_out;

    // unpack the command beat
    always_comb begin
        item.cmd        = t_cmd'(i_s_tuser);
        item.list_id    = i_s_tdata[1:0];
        item.node_index = i_s_tdata[9:2];
        item.count      = i_s_tdata[18:10];
        item.data_in    = i_s_tdata[50:19];
    end

    llpm_node_ram u_ram (
        .i_clk (i_clk),
        .i_req (ram_req),
        .o_rsp (ram_rsp)
    );

    llpm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_s_tvalid),
        .i_item       (item),
        .o_item_ready (o_s_tready),
        .o_res_valid  (seq_res_valid),
        .i_res_ready  (seq_res_ready),
        .o_res        (seq_res),
        .o_ram_req    (ram_req),
        .i_ram_rsp    (ram_rsp)
    );

    // output register: loads when empty or being drained this cycle
    assign seq_res_ready = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (seq_res_ready) begin
            r_ovalid <= seq_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_ready && seq_res_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {1'b0,
                         r_out.prev_link,
                         r_out.next_link,
                         r_out.data_out,
                         r_out.free_count,
                         r_out.list_length,
                         r_out.tail_index,
                         r_out.head_index,
                         r_out.touched_index};

endmodule

/* rtl/llpm_node_ram.sv */
// ----------------------------------------------------------------------------
// llpm_node_ram
// Node pool storage: next links, prev links and entry data, one write port
// per array and one shared registered read port.
// ----------------------------------------------------------------------------
module llpm_node_ram
    import llpm_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_ram_rsp o_rsp
);

    logic [LINK_W-1:0]     r_next [NUM_NODES];
    logic [LINK_W-1:0]     r_prev [NUM_NODES];
    logic [DATA_WIDTH-1:0] r_data [NUM_NODES];

    always_ff @(posedge i_clk) begin
        if (i_req.nx_we) begin
            r_next[i_req.nx_addr] <= i_req.nx_wdata;
        end
        if (i_req.pv_we) begin
            r_prev[i_req.pv_addr] <= i_req.pv_wdata;
        end
        if (i_req.dt_we) begin
            r_data[i_req.dt_addr] <= i_req.dt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rsp.next <= r_next[i_req.rd_addr];
            o_rsp.prev <= r_prev[i_req.rd_addr];
            o_rsp.data <= r_data[i_req.rd_addr];
        end
    end

endmodule

/* rtl/llpm_sat_alu.sv */
// ----------------------------------------------------------------------------
// llpm_sat_alu
// Shared saturating counter unit: increment capped at the pool size, or
// subtract clamped at zero with a borrow flag.
// ----------------------------------------------------------------------------
module llpm_sat_alu
    import llpm_pkg::*;
(
    input  t_alu_op i_op,
    input  t_link   i_a,
    input  t_link   i_b,
    output t_link   o_y,
    output logic    o_borrow
);

    logic [LINK_W:0] w_sum;

    always_comb begin
        w_sum    = '0;
        o_y      = i_a;
        o_borrow = 1'b0;
        unique case (i_op)
            ALU_INC: begin
                w_sum = {1'b0, i_a} + (LINK_W+1)'(1);
                o_y   = (i_a >= LINK_W'(NUM_NODES)) ? i_a : w_sum[LINK_W-1:0];
            end
            ALU_SUB: begin
                w_sum    = {1'b0, i_a} - {1'b0, i_b};
                o_borrow = w_sum[LINK_W];
                o_y      = w_sum[LINK_W] ? '0 : w_sum[LINK_W-1:0];
            end
            default: ;
        endcase
    end

endmodule

/* rtl/llpm_seq.sv */
// ----------------------------------------------------------------------------
// llpm_seq
// Command sequencer: list and free-list registers, memory sweep after reset,
// and the step-by-step link updates of every command.
// ----------------------------------------------------------------------------
module llpm_seq
    import llpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_item_valid,
    input  t_item    i_item,
    output logic     o_item_ready,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_result  o_res,
    output t_ram_req o_ram_req,
    input  t_ram_rsp i_ram_rsp
);

    t_state            r_state, n_state;
    logic [NODE_W-1:0] r_init_cnt, n_init_cnt;
    t_link             r_fh, n_fh;
    t_link             r_ft, n_ft;
    t_link             r_used, n_used;
    t_link             r_head [NUM_LISTS];
    t_link             n_head [NUM_LISTS];
    t_link             r_tail [NUM_LISTS];
    t_link             n_tail [NUM_LISTS];
    t_link             r_len  [NUM_LISTS];
    t_link             n_len  [NUM_LISTS];

    t_item                 r_item;
    t_link                 r_idx, n_idx;
    t_link                 r_touched, n_touched;
    t_status               r_status, n_status;
    t_link                 r_diff, n_diff;
    logic                  r_ovf, n_ovf;
    logic [DATA_WIDTH-1:0] r_dout, n_dout;
    t_link                 r_rnext, n_rnext;
    t_link                 r_rprev, n_rprev;

    t_alu_op alu_op;
    t_link   alu_a, alu_b, alu_y;
    logic    alu_borrow;

    t_link hd, tl, ln, lnode, rn, rp;
    logic  hd_none, tl_none, fh_none, chk_reject, drop_bad;

    llpm_sat_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    assign hd       = r_head[r_item.list_id];
    assign tl       = r_tail[r_item.list_id];
    assign ln       = r_len[r_item.list_id];
    assign lnode    = {1'b0, r_item.node_index};
    assign rn       = i_ram_rsp.next;
    assign rp       = i_ram_rsp.prev;
    assign hd_none  = (hd == LINK_NONE);
    assign tl_none  = (tl == LINK_NONE);
    assign fh_none  = (r_fh == LINK_NONE);
    assign drop_bad = (rp == LINK_NONE) || r_ovf;

    // early reject: full pool on allocate, empty list on the rest; read is never rejected
    always_comb begin
        unique case (r_item.cmd) inside
            CMD_APPEND, CMD_PREPEND: chk_reject = fh_none;
            CMD_POP_TAIL:            chk_reject = tl_none;
            CMD_READ:                chk_reject = 1'b0;
            default:                 chk_reject = hd_none;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_init_cnt == NODE_W'(NUM_NODES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_item_valid) n_state = S_CHK;
            end
            S_CHK: begin
                if (chk_reject)                    n_state = S_DONE;
                else if (r_item.cmd == CMD_CLEAR)  n_state = S_X1;
                else                               n_state = S_RD;
            end
            S_RD: n_state = S_X1;
            S_X1: begin
                unique case (r_item.cmd) inside
                    CMD_APPEND, CMD_PREPEND:             n_state = S_X2;
                    CMD_POP_HEAD, CMD_POP_TAIL, CMD_UNLINK: n_state = S_FP1;
                    CMD_DROP: n_state = drop_bad ? S_DONE : S_X2;
                    default:  n_state = S_DONE;
                endcase
            end
            S_X2:  n_state = (r_item.cmd == CMD_PREPEND) ? S_X3 : S_DONE;
            S_X3:  n_state = S_DONE;
            S_FP1: n_state = S_FP2;
            S_FP2: n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_init_cnt = r_init_cnt;
        n_fh       = r_fh;
        n_ft       = r_ft;
        n_used     = r_used;
        n_head     = r_head;
        n_tail     = r_tail;
        n_len      = r_len;
        n_idx      = r_idx;
        n_touched  = r_touched;
        n_status   = r_status;
        n_diff     = r_diff;
        n_ovf      = r_ovf;
        n_dout     = r_dout;
        n_rnext    = r_rnext;
        n_rprev    = r_rprev;
        o_ram_req  = '0;
        alu_op     = ALU_SUB;
        alu_a      = LINK_W'(NUM_NODES);   // free count in S_DONE
        alu_b      = r_used;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;

        unique case (r_state)
            S_INIT: begin
                o_ram_req.nx_we    = 1'b1;
                o_ram_req.nx_addr  = r_init_cnt;
                o_ram_req.nx_wdata = LINK_W'(r_init_cnt) + LINK_W'(1);
                o_ram_req.pv_we    = 1'b1;
                o_ram_req.pv_addr  = r_init_cnt;
                o_ram_req.pv_wdata = (r_init_cnt == '0) ? LINK_NONE
                                                        : LINK_W'(r_init_cnt) - LINK_W'(1);
                n_init_cnt = r_init_cnt + NODE_W'(1);
            end

            S_IDLE: o_item_ready = 1'b1;

            S_CHK: begin
                n_status  = ST_OK;
                n_touched = LINK_NONE;
                n_dout    = '0;
                n_rnext   = LINK_NONE;
                n_rprev   = LINK_NONE;
                n_idx     = lnode;
                unique case (r_item.cmd) inside
                    CMD_APPEND, CMD_PREPEND: begin
                        if (fh_none) begin
                            n_status = ST_FULL;
                        end else begin
                            n_idx     = r_fh;
                            n_touched = r_fh;
                        end
                    end
                    CMD_POP_HEAD: begin
                        if (hd_none) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_idx     = hd;
                            n_touched = hd;
                        end
                    end
                    CMD_POP_TAIL: begin
                        if (tl_none) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_idx     = tl;
                            n_touched = tl;
                        end
                    end
                    CMD_UNLINK: begin
                        if (hd_none) n_status = ST_EMPTY;
                        else         n_touched = lnode;
                    end
                    CMD_CLEAR: begin
                        if (hd_none) n_status = ST_EMPTY;
                        else         n_touched = hd;
                    end
                    CMD_DROP: begin
                        if (hd_none) n_status = ST_EMPTY;
                        // length minus count; borrow flags a count that is too large
                        alu_a  = ln;
                        alu_b  = r_item.count;
                        n_diff = alu_y;
                        n_ovf  = alu_borrow;
                    end
                    default: ;
                endcase
            end

            S_RD: begin
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_addr = r_idx[NODE_W-1:0];
            end

            S_X1: begin
                unique case (r_item.cmd) inside
                    CMD_APPEND, CMD_PREPEND: begin
                        // pop the free-list head
                        n_fh = rn;
                        if (rn != LINK_NONE) begin
                            o_ram_req.pv_we    = 1'b1;
                            o_ram_req.pv_addr  = rn[NODE_W-1:0];
                            o_ram_req.pv_wdata = LINK_NONE;
                        end else begin
                            n_ft = LINK_NONE;
                        end
                        alu_op = ALU_INC;
                        alu_a  = r_used;
                        n_used = alu_y;
                        o_ram_req.dt_we    = 1'b1;
                        o_ram_req.dt_addr  = r_idx[NODE_W-1:0];
                        o_ram_req.dt_wdata = r_item.data_in;
                        o_ram_req.nx_we    = 1'b1;
                        o_ram_req.nx_addr  = r_idx[NODE_W-1:0];
                        o_ram_req.nx_wdata = (r_item.cmd == CMD_APPEND) ? LINK_NONE : hd;
                    end
                    CMD_POP_HEAD: begin
                        n_head[r_item.list_id] = rn;
                        if (rn != LINK_NONE) begin
                            o_ram_req.pv_we    = 1'b1;
                            o_ram_req.pv_addr  = rn[NODE_W-1:0];
                            o_ram_req.pv_wdata = LINK_NONE;
                        end else begin
                            n_tail[r_item.list_id] = LINK_NONE;
                        end
                        alu_a = ln;
                        alu_b = LINK_W'(1);
                        n_len[r_item.list_id] = alu_y;
                    end
                    CMD_POP_TAIL: begin
                        n_tail[r_item.list_id] = rp;
                        if (rp != LINK_NONE) begin
                            o_ram_req.nx_we    = 1'b1;
                            o_ram_req.nx_addr  = rp[NODE_W-1:0];
                            o_ram_req.nx_wdata = LINK_NONE;
                        end else begin
                            n_head[r_item.list_id] = LINK_NONE;
                        end
                        alu_a = ln;
                        alu_b = LINK_W'(1);
                        n_len[r_item.list_id] = alu_y;
                    end
                    CMD_UNLINK: begin
                        if (rp != LINK_NONE) begin
                            o_ram_req.nx_we    = 1'b1;
                            o_ram_req.nx_addr  = rp[NODE_W-1:0];
                            o_ram_req.nx_wdata = rn;
                        end else begin
                            n_head[r_item.list_id] = rn;
                        end
                        if (rn != LINK_NONE) begin
                            o_ram_req.pv_we    = 1'b1;
                            o_ram_req.pv_addr  = rn[NODE_W-1:0];
                            o_ram_req.pv_wdata = rp;
                        end else begin
                            n_tail[r_item.list_id] = rp;
                        end
                        alu_a = ln;
                        alu_b = LINK_W'(1);
                        n_len[r_item.list_id] = alu_y;
                    end
                    CMD_CLEAR: begin
                        // splice the whole list in front of the free list
                        if (!tl_none) begin
                            o_ram_req.nx_we    = 1'b1;
                            o_ram_req.nx_addr  = tl[NODE_W-1:0];
                            o_ram_req.nx_wdata = r_fh;
                        end
                        if (!fh_none) begin
                            o_ram_req.pv_we    = 1'b1;
                            o_ram_req.pv_addr  = r_fh[NODE_W-1:0];
                            o_ram_req.pv_wdata = tl;
                        end else begin
                            n_ft = tl;
                        end
                        n_fh   = hd;
                        alu_a  = r_used;
                        alu_b  = ln;
                        n_used = alu_y;
                        n_head[r_item.list_id] = LINK_NONE;
                        n_tail[r_item.list_id] = LINK_NONE;
                        n_len[r_item.list_id]  = '0;
                    end
                    CMD_DROP: begin
                        if (drop_bad) begin
                            n_status = ST_IGNORED;
                        end else begin
                            n_touched          = hd;
                            o_ram_req.nx_we    = 1'b1;
                            o_ram_req.nx_addr  = rp[NODE_W-1:0];
                            o_ram_req.nx_wdata = r_fh;
                            if (!fh_none) begin
                                o_ram_req.pv_we    = 1'b1;
                                o_ram_req.pv_addr  = r_fh[NODE_W-1:0];
                                o_ram_req.pv_wdata = rp;
                            end else begin
                                n_ft = rp;
                            end
                            n_fh   = hd;
                            alu_a  = r_used;
                            alu_b  = r_item.count;
                            n_used = alu_y;
                        end
                    end
                    default: begin
                        n_dout  = i_ram_rsp.data;
                        n_rnext = rn;
                        n_rprev = rp;
                    end
                endcase
            end

            S_X2: begin
                unique case (r_item.cmd)
                    CMD_APPEND: begin
                        o_ram_req.pv_we    = 1'b1;
                        o_ram_req.pv_addr  = r_idx[NODE_W-1:0];
                        o_ram_req.pv_wdata = tl;
                        if (!tl_none) begin
                            o_ram_req.nx_we    = 1'b1;
                            o_ram_req.nx_addr  = tl[NODE_W-1:0];
                            o_ram_req.nx_wdata = r_idx;
                        end else begin
                            n_head[r_item.list_id] = r_idx;
                        end
                        n_tail[r_item.list_id] = r_idx;
                        alu_op = ALU_INC;
                        alu_a  = ln;
                        n_len[r_item.list_id] = alu_y;
                    end
                    CMD_PREPEND: begin
                        o_ram_req.pv_we    = 1'b1;
                        o_ram_req.pv_addr  = r_idx[NODE_W-1:0];
                        o_ram_req.pv_wdata = LINK_NONE;
                    end
                    CMD_DROP: begin
                        o_ram_req.pv_we    = 1'b1;
                        o_ram_req.pv_addr  = r_item.node_index;
                        o_ram_req.pv_wdata = LINK_NONE;
                        n_head[r_item.list_id] = lnode;
                        n_len[r_item.list_id]  = r_diff;
                    end
                    default: ;
                endcase
            end

            S_X3: begin
                if (!hd_none) begin
                    o_ram_req.pv_we    = 1'b1;
                    o_ram_req.pv_addr  = hd[NODE_W-1:0];
                    o_ram_req.pv_wdata = r_idx;
                end else begin
                    n_tail[r_item.list_id] = r_idx;
                end
                n_head[r_item.list_id] = r_idx;
                alu_op = ALU_INC;
                alu_a  = ln;
                n_len[r_item.list_id] = alu_y;
            end

            // push r_idx onto the free-list head
            S_FP1: begin
                o_ram_req.pv_we    = 1'b1;
                o_ram_req.pv_addr  = r_idx[NODE_W-1:0];
                o_ram_req.pv_wdata = LINK_NONE;
                o_ram_req.nx_we    = 1'b1;
                o_ram_req.nx_addr  = r_idx[NODE_W-1:0];
                o_ram_req.nx_wdata = r_fh;
            end

            S_FP2: begin
                if (!fh_none) begin
                    o_ram_req.pv_we    = 1'b1;
                    o_ram_req.pv_addr  = r_fh[NODE_W-1:0];
                    o_ram_req.pv_wdata = r_idx;
                end else begin
                    n_ft = r_idx;
                end
                n_fh   = r_idx;
                alu_a  = r_used;
                alu_b  = LINK_W'(1);
                n_used = alu_y;
            end

            S_DONE: o_res_valid = 1'b1;

            default: ;
        endcase
    end

    assign o_res.status        = r_status;
    assign o_res.touched_index = r_touched;
    assign o_res.head_index    = hd;
    assign o_res.tail_index    = tl;
    assign o_res.list_length   = ln;
    assign o_res.free_count    = alu_y;
    assign o_res.data_out      = r_dout;
    assign o_res.next_link     = r_rnext;
    assign o_res.prev_link     = r_rprev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_cnt <= '0;
            r_fh       <= '0;
            r_ft       <= LINK_W'(NUM_NODES - 1);
            r_used     <= '0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head[i] <= LINK_NONE;
                r_tail[i] <= LINK_NONE;
                r_len[i]  <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_init_cnt <= n_init_cnt;
            r_fh       <= n_fh;
            r_ft       <= n_ft;
            r_used     <= n_used;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_len      <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_item <= i_item;
        end
        r_idx     <= n_idx;
        r_touched <= n_touched;
        r_status  <= n_status;
        r_diff    <= n_diff;
        r_ovf     <= n_ovf;
        r_dout    <= n_dout;
        r_rnext   <= n_rnext;
        r_rprev   <= n_rprev;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item_ready && i_item_valid) |=> (r_state == S_CHK))
        else $error("sequencer did not start on accepted beat");

    a_free_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fh == LINK_NONE) |-> (r_ft == LINK_NONE))
        else $error("free list empty but free tail still set");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used <= LINK_W'(NUM_NODES)))
        else $error("used node count above pool size");

    a_full_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == ST_FULL))
            |-> (r_item.cmd == CMD_APPEND || r_item.cmd == CMD_PREPEND))
        else $error("pool-full status on a non-allocating command");

endmodule
